>>> rtl/scp_pkg.sv
package scp_pkg;

   // Reduced angle path width, Q.32 radians
   localparam int FW = 36;
   // Polynomial datapath width, Q.30
   localparam int DW = 33;
   // Raw product width of two polynomial operands
   localparam int PRW = 2 * DW;

   localparam logic signed [FW-1:0] PI_Q32      = 36'sd13493037705;
   localparam logic signed [FW-1:0] HALF_PI_Q32 = 36'sd6746518852;
   localparam logic signed [FW-1:0] TWO_PI_Q32  = 36'sd26986075410;

   localparam logic signed [DW-1:0] C3_Q30  = -33'sd178956868;
   localparam logic signed [DW-1:0] C5_Q30  = 33'sd8947509;
   localparam logic signed [DW-1:0] C7_Q30  = -33'sd212672;
   localparam logic signed [DW-1:0] C9_Q30  = 33'sd2792;
   localparam logic signed [DW-1:0] ONE_Q30 = 33'sd1073741824;

   localparam logic [PRW-1:0] RND_HALF_Q30 = PRW'(1) << 29;

   // Function select carried by the req word
   typedef enum logic {
      OP_SINE   = 1'b0,
      OP_COSINE = 1'b1
   } scp_op_type;

   // Folded angle word handed from the range reduction to the polynomial
   typedef struct packed {
      logic                 neg;
      logic signed [DW-1:0] a30;
   } scp_arg_type;

   // Round a Q.60 product back to Q.30, nearest with ties away from zero
   function automatic logic signed [DW-1:0] rnd_q30(input logic signed [PRW-1:0] p);
      logic [PRW-1:0] s;
      s = p + RND_HALF_Q30 - {{(PRW-1){1'b0}}, p[PRW-1]};
      return s[30+DW-1:30];
   endfunction

endpackage

>>> rtl/sine_cosine_polynomial_approx_core.sv
// Sine / cosine core, degree-9 odd polynomial in fixed point.
// Path from req word accepted to rsp word valid:
//   7 range reduction stages, 11 polynomial stages, 1 output register.
// Throughput: one word per cycle when not stalled; each stage holds one word and fills bubbles.
// Reset: synchronous, active high; clears every stage valid bit, drops words in flight.
module sine_cosine_polynomial_approx_core
   import scp_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS  = 24,
   parameter int RESULT_FRAC_BITS = 30
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_op,
   input  logic signed [31:0] req_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_value
);

   // Output rounding from Q.30 to the result format
   localparam int DS = 30 - RESULT_FRAC_BITS;
   localparam logic signed [DW-1:0] OUT_HALF = (DS == 0) ? '0 : (DW'(1) <<< (DS - 1));
   localparam logic signed [DW-1:0] OUT_LIM  = DW'(1) <<< RESULT_FRAC_BITS;

   logic                 wrap_valid, wrap_ready;
   scp_arg_type          wrap_arg;
   logic                 poly_valid, poly_ready;
   logic signed [DW-1:0] poly_y;

   logic                 rsp_valid_ff;
   logic signed [31:0]   rsp_value_ff, rsp_value_in;
   logic signed [DW-1:0] rs, res;
   logic                 out_en;

   // Range reduction: scale to Q.32, add pi/2 for cosine, exact modulo 2*pi by a
   // reciprocal estimate plus correction, fold, and round the magnitude to Q.30.
   scp_wrap #(
      .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
   ) u_wrap (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_op    (req_op),
      .in_angle (req_angle),
      .out_valid(wrap_valid),
      .out_ready(wrap_ready),
      .out_arg  (wrap_arg)
   );

   // Horner evaluation, each product registered and rounded in the following stage
   scp_poly u_poly (
      .clock    (clock),
      .reset    (reset),
      .in_valid (wrap_valid),
      .in_ready (wrap_ready),
      .in_arg   (wrap_arg),
      .out_valid(poly_valid),
      .out_ready(poly_ready),
      .out_y    (poly_y)
   );

   // Output register: load when empty or when the held word is taken
   assign out_en     = !rsp_valid_ff || rsp_ready;
   assign poly_ready = out_en;

   always_comb begin
      // round to nearest, ties away from zero
      rs  = poly_y + OUT_HALF - {{(DW-1){1'b0}}, (DS != 0) && poly_y[DW-1]};
      res = rs >>> DS;
      // clamp to -1.0..+1.0 of the result format
      if (res > OUT_LIM) begin
         res = OUT_LIM;
      end else if (res < -OUT_LIM) begin
         res = -OUT_LIM;
      end
      rsp_value_in = res[31:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= poly_valid;
      end
   end

   // hold the payload while the word waits
   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

endmodule

>>> rtl/scp_wrap.sv
module scp_wrap
   import scp_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                in_op,
   input  logic signed [31:0]  in_angle,
   output logic                out_valid,
   input  logic                out_ready,
   output scp_arg_type         out_arg
);

   localparam int SH  = 32 - ANGLE_FRAC_BITS;
   localparam int TS  = SH + 2;
   localparam int VW  = 32 + TS;
   localparam int QW  = TS - 1;
   localparam int RW  = TS + 6;
   localparam int PW  = 33 + RW;
   localparam int NST = 7;

   localparam logic [63:0]    RECIP64 = (64'd1 << (TS + 40)) / 64'(TWO_PI_Q32);
   localparam logic [RW-1:0]  RECIP   = RECIP64[RW-1:0];

   localparam logic signed [VW-1:0] PI_V      = VW'(PI_Q32);
   localparam logic signed [VW-1:0] HALF_PI_V = VW'(HALF_PI_Q32);
   localparam logic signed [VW-1:0] TWO_PI_V  = VW'(TWO_PI_Q32);
   localparam logic signed [VW-1:0] FOUR_PI_V = 4 * PI_V;
   localparam logic signed [VW-1:0] RED1_V    = PI_V;
   localparam logic signed [VW-1:0] RED3_V    = 3 * PI_V;
   localparam logic signed [VW-1:0] RED5_V    = 5 * PI_V;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] en;

   logic signed [VW-1:0] v0_ff, v0_in, v1_ff, v2_ff, v3_ff;
   logic signed [PW-1:0] prod1_ff, prod1_in;
   logic signed [QW-1:0] q2_ff, q2_in;
   logic signed [VW-1:0] qm3_ff, qm3_in;
   logic signed [VW-1:0] m4_ff, m4_in;
   logic signed [FW-1:0] r5_ff, r5_in;
   logic signed [VW-1:0] r5_full;
   scp_arg_type          arg6_ff, arg6_in;
   logic signed [FW-1:0] mag, mag2;
   logic signed [VW-1:0] ang_w;

   // a stage advances when any stage at or after it is empty, or the output drains
   always_comb begin
      for (int k = 0; k < NST; k++) begin
         en[k] = out_ready || ((vld_ff | NST'((1 << k) - 1)) != '1);
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NST-1];
   assign out_arg   = arg6_ff;

   always_comb begin
      ang_w    = VW'(in_angle);
      v0_in    = (ang_w <<< SH) + ((in_op == OP_COSINE) ? HALF_PI_V : '0) + PI_V;
      prod1_in = $signed(v0_ff[VW-1:TS]) * $signed({1'b0, RECIP});
      // estimate is low by at most two turns
      q2_in    = prod1_ff[PW-1:40] - QW'(1);
      qm3_in   = VW'(q2_ff) * TWO_PI_V;
      m4_in    = v3_ff - qm3_ff;
      if (m4_ff >= FOUR_PI_V) begin
         r5_full = m4_ff - RED5_V;
      end else if (m4_ff >= TWO_PI_V) begin
         r5_full = m4_ff - RED3_V;
      end else begin
         r5_full = m4_ff - RED1_V;
      end
      r5_in = r5_full[FW-1:0];

      // fold into -pi/2..pi/2 and take the magnitude
      if (r5_ff > HALF_PI_Q32) begin
         mag         = PI_Q32 - r5_ff;
         arg6_in.neg = 1'b0;
      end else if (r5_ff < -HALF_PI_Q32) begin
         mag         = PI_Q32 + r5_ff;
         arg6_in.neg = (r5_ff != -PI_Q32);
      end else begin
         arg6_in.neg = r5_ff[FW-1];
         mag         = r5_ff[FW-1] ? -r5_ff : r5_ff;
      end
      mag2        = mag + FW'(2);
      arg6_in.a30 = mag2[DW+1:2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         v0_ff <= v0_in;
      end
      if (en[1]) begin
         v1_ff    <= v0_ff;
         prod1_ff <= prod1_in;
      end
      if (en[2]) begin
         v2_ff <= v1_ff;
         q2_ff <= q2_in;
      end
      if (en[3]) begin
         v3_ff  <= v2_ff;
         qm3_ff <= qm3_in;
      end
      if (en[4]) begin
         m4_ff <= m4_in;
      end
      if (en[5]) begin
         r5_ff <= r5_in;
      end
      if (en[6]) begin
         arg6_ff <= arg6_in;
      end
   end

endmodule

>>> rtl/scp_poly.sv
module scp_poly
   import scp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  scp_arg_type          in_arg,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic signed [DW-1:0] out_y
);

   localparam int NST = 11;

   typedef struct packed {
      logic                  neg;
      logic signed [DW-1:0]  a30;
      logic signed [DW-1:0]  x2;
      logic signed [DW-1:0]  x3;
      logic signed [DW-1:0]  acc;
      logic signed [PRW-1:0] pr;
      logic signed [PRW-1:0] pr2;
   } poly_stage_type;

   logic [NST-1:0] vld_ff;
   logic [NST-1:0] en;
   poly_stage_type st_ff [NST];
   poly_stage_type st_in [NST];

   always_comb begin
      for (int k = 0; k < NST; k++) begin
         en[k] = out_ready || ((vld_ff | NST'((1 << k) - 1)) != '1);
      end
   end

   assign in_ready  = en[0];
   assign out_valid = vld_ff[NST-1];
   assign out_y     = st_ff[NST-1].acc;

   always_comb begin
      st_in[0]     = '0;
      st_in[0].neg = in_arg.neg;
      st_in[0].a30 = in_arg.a30;
      st_in[0].pr  = in_arg.a30 * in_arg.a30;
      for (int k = 1; k < NST; k++) begin
         st_in[k] = st_ff[k-1];
      end
      st_in[1].x2  = rnd_q30(st_ff[0].pr);
      st_in[2].pr  = st_ff[1].x2 * C9_Q30;
      st_in[2].pr2 = st_ff[1].a30 * st_ff[1].x2;
      st_in[3].acc = C7_Q30 + rnd_q30(st_ff[2].pr);
      st_in[3].x3  = rnd_q30(st_ff[2].pr2);
      st_in[4].pr  = st_ff[3].x2 * st_ff[3].acc;
      st_in[5].acc = C5_Q30 + rnd_q30(st_ff[4].pr);
      st_in[6].pr  = st_ff[5].x2 * st_ff[5].acc;
      st_in[7].acc = C3_Q30 + rnd_q30(st_ff[6].pr);
      st_in[8].pr  = st_ff[7].x3 * st_ff[7].acc;
      st_in[9].acc = st_ff[8].a30 + rnd_q30(st_ff[8].pr);
      // clamp to unit range, then restore the sign
      if (st_ff[9].acc > ONE_Q30) begin
         st_in[10].acc = ONE_Q30;
      end else if (st_ff[9].acc < -ONE_Q30) begin
         st_in[10].acc = -ONE_Q30;
      end else begin
         st_in[10].acc = st_ff[9].acc;
      end
      if (st_ff[9].neg) begin
         st_in[10].acc = -st_in[10].acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (en[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

endmodule

>>> rtl/scp_checker.sv
module scp_checker #(
   parameter int RESULT_FRAC_BITS = 30
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_op,
   input logic signed [31:0] req_angle,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_value
);

   localparam logic signed [32:0] LIM = 33'sd1 <<< RESULT_FRAC_BITS;

   // reset empties the output
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value))
      else $error("rsp word changed while stalled");

   // an empty output leaves the whole pipeline free to take a word
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // result stays in -1.0..+1.0
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_value) <= LIM) && ($signed(rsp_value) >= -LIM))
      else $error("rsp_value out of range");

   // a waiting req word holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable({req_op, req_angle}))
      else $error("req word changed while waiting");

endmodule

bind sine_cosine_polynomial_approx_core scp_checker #(
   .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
) u_scp_checker (.*);
